[rtl/core/aes_ecb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES block cipher package
// Shared types, register indexes, S-box and round helper functions.
// ----------------------------------------------------------------------------
package aes_ecb_pkg;

	localparam int unsigned RegW = 64;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned RkDepth = 60;
	localparam int unsigned RkAddrW = 6;

	localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CHAIN_MODE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_IV_LOW = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_IV_HIGH = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_WR,
		ST_ENC_RD,
		ST_ENC_RND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
		logic        last_out;
	} result_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	// State byte i sits at bits 8i+7:8i; column c is bytes 4c..4c+3.
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[8*(4*c+r) +: 8] = SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[32*c +: 8];
			a1 = s[32*c+8 +: 8];
			a2 = s[32*c+16 +: 8];
			a3 = s[32*c+24 +: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[32*c +: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[32*c+8 +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		mix_columns = t;
	endfunction

endpackage

[rtl/core/aes_ecb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES stream channel
// Valid/ready channel carrying one block transaction.
// ----------------------------------------------------------------------------
interface aes_blk_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_low;
	logic [63:0] block_high;
	logic        restart_chain;
	logic        last_block;
	modport source (output valid, block_low, block_high, restart_chain, last_block,
		input ready);
	modport sink (input valid, block_low, block_high, restart_chain, last_block,
		output ready);
endinterface

interface aes_blk_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] cipher_low;
	logic [63:0] cipher_high;
	logic        last_out;
	modport source (output valid, cipher_low, cipher_high, last_out, input ready);
	modport sink (input valid, cipher_low, cipher_high, last_out, output ready);
endinterface

[rtl/core/aes_block_encrypt_ecb_cbc_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128/192/256 forward cipher, ECB or CBC
// Encrypts one 16-byte block per transaction using a key schedule held in a
// 60-word synchronous RAM.
// ----------------------------------------------------------------------------
// Each input transaction gives one ciphertext transaction. After reset or any
// configuration write, the first block triggers a key expansion: each
// round-key word takes a RAM read of word i-nk, then a write of word i, for
// 4*(nr+1) words (44 for 128-bit, 52 for 192-bit, 60 for 256-bit keys).
// Each block then steps through the accepting cycle, a fetch of round key 0,
// nr+1 round steps (initial key add plus nr rounds), each fed by the single
// round-key RAM read port delivering one 128-bit round key (four words read
// as one row) per cycle, and one output step. A finished result waits in the
// output register while the next block is accepted and enciphered; that block
// holds in its output step until the register has been taken. Configuration
// must be written only while idle; key_size 3 behaves as 2.
// ----------------------------------------------------------------------------
module aes_block_encrypt_ecb_cbc_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [aes_ecb_pkg::CfgIdxW-1:0]       cfg_idx,
	input  logic [aes_ecb_pkg::RegW-1:0]          cfg_data,
	aes_blk_in_if.sink                            in_ch,
	aes_blk_out_if.source                         out_ch
);

	// Round-key RAM: 15 rows of four words, written one word at a time.
	logic [31:0] rk_mem [15][4];
	logic [127:0] rk_rd_s1;
	logic [31:0]  wd_rd_s1;

	logic [1:0]   key_size_q;
	logic         chain_mode_q;
	logic [63:0]  key_q [4];
	logic [63:0]  iv_q [2];
	logic         sched_ok_q;
	logic [127:0] chain_q;
	logic [127:0] st_q;
	logic         last_q;
	logic [5:0]   wi_q;      // word index during expansion
	logic [31:0]  prev_q;    // word i-1
	logic [3:0]   rnd_q;
	logic [3:0]   rcon_q;    // rcon index
	logic [2:0]   mod_q;     // i mod nk
	aes_ecb_pkg::result_t res_q;
	logic         res_vld_q;
	aes_ecb_pkg::state_t st_cur_q, st_nxt;

	logic [1:0] sc;
	logic [3:0] nr;
	logic [2:0] nk_m1;
	logic [5:0] total;
	assign sc = (key_size_q[1]) ? 2'd2 : key_size_q;
	assign nr = 4'd10 + {1'b0, sc, 1'b0};
	assign nk_m1 = 3'd3 + {sc, 1'b0};
	assign total = {nr + 4'd1, 2'b00};

	// Key-word source for the first nk words.
	logic [31:0] key_word;
	assign key_word = wi_q[0] ? key_q[wi_q[2:1]][63:32] : key_q[wi_q[2:1]][31:0];

	logic [7:0] rcon;
	always_comb begin
		case (rcon_q)
			4'd0: rcon = 8'h01;
			4'd1: rcon = 8'h02;
			4'd2: rcon = 8'h04;
			4'd3: rcon = 8'h08;
			4'd4: rcon = 8'h10;
			4'd5: rcon = 8'h20;
			4'd6: rcon = 8'h40;
			4'd7: rcon = 8'h80;
			4'd8: rcon = 8'h1B;
			4'd9: rcon = 8'h36;
			default: rcon = 8'h01;
		endcase
	end

	logic [31:0] tword, new_word;
	always_comb begin
		tword = prev_q;
		if (mod_q == 3'd0) begin
			tword = aes_ecb_pkg::sub_word({prev_q[7:0], prev_q[31:8]}) ^ {24'd0, rcon};
		end else if (sc == 2'd2 && mod_q == 3'd4) begin
			tword = aes_ecb_pkg::sub_word(prev_q);
		end
		new_word = (wi_q <= {3'd0, nk_m1}) ? key_word : (wd_rd_s1 ^ tword);
	end

	logic [5:0] rd_word;
	assign rd_word = wi_q - {3'd0, nk_m1} - 6'd1;

	// Round datapath: middle rounds mix, last round does not.
	logic [127:0] ss, rnd_out;
	assign ss = aes_ecb_pkg::sub_shift(st_q);
	assign rnd_out = ((rnd_q == nr) ? ss : aes_ecb_pkg::mix_columns(ss)) ^ rk_rd_s1;

	logic in_acc, out_acc, rk_we, rk_re, res_load;
	logic [3:0] rk_row;
	assign in_acc = in_ch.valid & in_ch.ready;
	assign out_acc = out_ch.valid & out_ch.ready;
	assign in_ch.ready = (st_cur_q == aes_ecb_pkg::ST_IDLE);
	// Load the result register once it is empty or being taken this cycle.
	assign res_load = (st_cur_q == aes_ecb_pkg::ST_OUT) & (~res_vld_q | out_acc);
	assign rk_we = (st_cur_q == aes_ecb_pkg::ST_EXP_WR);
	assign rk_re = (st_cur_q == aes_ecb_pkg::ST_ENC_RD)
		| ((st_cur_q == aes_ecb_pkg::ST_ENC_RND) & (rnd_q != nr));
	assign rk_row = (st_cur_q == aes_ecb_pkg::ST_ENC_RD) ? 4'd0 : rnd_q + 4'd1;

	always_ff @(posedge clk) begin
		if (rk_we) begin
			rk_mem[wi_q[5:2]][wi_q[1:0]] <= new_word;
		end
		wd_rd_s1 <= rk_mem[rd_word[5:2]][rd_word[1:0]];
		if (rk_re) begin
			rk_rd_s1 <= {rk_mem[rk_row][3], rk_mem[rk_row][2], rk_mem[rk_row][1],
				rk_mem[rk_row][0]};
		end
	end

	always_comb begin
		st_nxt = st_cur_q;
		case (st_cur_q)
			aes_ecb_pkg::ST_IDLE: begin
				if (in_acc) begin
					st_nxt = sched_ok_q ? aes_ecb_pkg::ST_ENC_RD : aes_ecb_pkg::ST_EXP_RD;
				end
			end
			aes_ecb_pkg::ST_EXP_RD: st_nxt = aes_ecb_pkg::ST_EXP_WR;
			aes_ecb_pkg::ST_EXP_WR: begin
				st_nxt = (wi_q == total - 6'd1) ? aes_ecb_pkg::ST_ENC_RD
					: aes_ecb_pkg::ST_EXP_RD;
			end
			aes_ecb_pkg::ST_ENC_RD: st_nxt = aes_ecb_pkg::ST_ENC_RND;
			aes_ecb_pkg::ST_ENC_RND: begin
				if (rnd_q == nr) begin
					st_nxt = aes_ecb_pkg::ST_OUT;
				end
			end
			aes_ecb_pkg::ST_OUT: begin
				if (res_load) begin
					st_nxt = aes_ecb_pkg::ST_IDLE;
				end
			end
			default: st_nxt = aes_ecb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_cur_q <= aes_ecb_pkg::ST_IDLE;
			key_size_q <= '0;
			chain_mode_q <= 1'b0;
			key_q <= '{default: '0};
			iv_q <= '{default: '0};
			sched_ok_q <= 1'b0;
			chain_q <= '0;
			res_vld_q <= 1'b0;
			wi_q <= '0;
			prev_q <= '0;
			rnd_q <= '0;
			rcon_q <= '0;
			mod_q <= '0;
		end else begin
			st_cur_q <= st_nxt;
			if (cfg_we) begin
				sched_ok_q <= 1'b0;
				case (cfg_idx)
					aes_ecb_pkg::REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
					aes_ecb_pkg::REG_CHAIN_MODE: chain_mode_q <= cfg_data[0];
					aes_ecb_pkg::REG_KEY0: key_q[0] <= cfg_data;
					aes_ecb_pkg::REG_KEY1: key_q[1] <= cfg_data;
					aes_ecb_pkg::REG_KEY2: key_q[2] <= cfg_data;
					aes_ecb_pkg::REG_KEY3: key_q[3] <= cfg_data;
					aes_ecb_pkg::REG_IV_LOW: iv_q[0] <= cfg_data;
					aes_ecb_pkg::REG_IV_HIGH: iv_q[1] <= cfg_data;
					default: ;
				endcase
			end
			res_vld_q <= res_load | (res_vld_q & ~out_acc);
			case (st_cur_q)
				aes_ecb_pkg::ST_IDLE: begin
					if (in_acc) begin
						// Reload the chaining value from the IV on restart; in CBC mode the block is whitened with the IV directly.
						if (in_ch.restart_chain) begin
							chain_q <= {iv_q[1], iv_q[0]};
						end
						wi_q <= '0;
						mod_q <= '0;
						rcon_q <= '0;
						prev_q <= '0;
					end
				end
				aes_ecb_pkg::ST_EXP_WR: begin
					// Advance to the next schedule word.
					prev_q <= new_word;
					wi_q <= wi_q + 6'd1;
					if (mod_q == nk_m1) begin
						mod_q <= '0;
						if (wi_q > {3'd0, nk_m1}) begin
							rcon_q <= rcon_q + 4'd1;
						end
					end else begin
						mod_q <= mod_q + 3'd1;
					end
					if (wi_q == total - 6'd1) begin
						sched_ok_q <= 1'b1;
					end
				end
				aes_ecb_pkg::ST_ENC_RD: rnd_q <= '0;
				aes_ecb_pkg::ST_ENC_RND: rnd_q <= rnd_q + 4'd1;
				aes_ecb_pkg::ST_OUT: begin
					if (res_load && chain_mode_q) begin
						chain_q <= st_q;
					end
				end
				default: rnd_q <= rnd_q;
			endcase
		end
	end

	// Payload: state register and result.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			st_q <= {in_ch.block_high, in_ch.block_low} ^ (chain_mode_q
				? (in_ch.restart_chain ? {iv_q[1], iv_q[0]} : chain_q) : 128'd0);
			last_q <= in_ch.last_block;
		end else if (st_cur_q == aes_ecb_pkg::ST_ENC_RND) begin
			st_q <= (rnd_q == 4'd0) ? (st_q ^ rk_rd_s1) : rnd_out;
		end
		if (res_load) begin
			res_q.cipher_low <= st_q[63:0];
			res_q.cipher_high <= st_q[127:64];
			res_q.last_out <= last_q;
		end
	end

	assign out_ch.valid = res_vld_q;
	assign out_ch.cipher_low = res_q.cipher_low;
	assign out_ch.cipher_high = res_q.cipher_high;
	assign out_ch.last_out = res_q.last_out;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> st_cur_q != aes_ecb_pkg::ST_IDLE)
		else $error("accept did not start work");
	a_sched_before_enc: assert property (@(posedge clk) disable iff (!arst_n)
		(st_cur_q == aes_ecb_pkg::ST_ENC_RD) |-> sched_ok_q)
		else $error("encrypt without schedule");
	a_out_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_vld_q) |-> $past(st_cur_q) == aes_ecb_pkg::ST_OUT)
		else $error("result raised outside output state");

endmodule
